// ===== rtl/thta_pkg.sv =====
// Shared types and constants for the thermistor temperature averager.
// No dependencies; every other file in rtl but thta_ram and thta_checker imports this package.
package thta_pkg;

    localparam int ADC_W  = 10;
    localparam int KOHM_W = 10;
    localparam int NUM_W  = 30;
    localparam int COEF_W = 32;
    localparam int TEMP_W = 16;
    localparam int DIV_W  = 64;
    localparam int QUO_W  = 16;

    localparam logic [1:0] REG_COEF_A = 2'd0;
    localparam logic [1:0] REG_COEF_B = 2'd1;
    localparam logic [1:0] REG_COEF_C = 2'd2;
    localparam logic [1:0] REG_SERIES = 2'd3;

    localparam logic signed [COEF_W-1:0] COEF_A_RST = 32'sd1780551011;
    localparam logic signed [COEF_W-1:0] COEF_B_RST = 32'sd159273830;
    localparam logic signed [COEF_W-1:0] COEF_C_RST = 32'sd558548;
    localparam logic [KOHM_W-1:0]        SERIES_RST = 10'd10;

    localparam logic [ADC_W-1:0]         ADC_MAX     = 10'd1023;
    localparam logic signed [TEMP_W-1:0] RAIL_TENTHS = -16'sd4596;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX    = 16'sd32767;

    typedef struct packed {
        logic [ADC_W-1:0] adc_sample;
        logic [NUM_W-1:0] num;
        logic             rail;
        logic             kzero;
    } t_item;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic             ovf;
        logic [QUO_W-1:0] quo;
    } t_div_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM,
        ST_SQR,
        ST_LN,
        ST_L2,
        ST_L3,
        ST_TB,
        ST_TC,
        ST_SUM,
        ST_TOP,
        ST_TSTART,
        ST_TDIV,
        ST_AVG,
        ST_ASTART,
        ST_ADIV,
        ST_OUT
    } t_state;

endpackage

// ===== rtl/thta_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module thta_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/thta_front.sv =====
// Front end: accepts ADC beats, flags rail and zero-resistor cases and forms
// the divider numerator series_kohm*1000*(1023-x). Depends on thta_pkg.
module thta_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [thta_pkg::ADC_W-1:0]    i_adc_sample,
    input  logic [thta_pkg::KOHM_W-1:0]   i_series_kohm,
    output logic                          o_item_push,
    output thta_pkg::t_item               o_item,
    input  logic                          i_q_full
);
    import thta_pkg::*;

    logic                  r_fv;
    logic [ADC_W-1:0]      r_x;
    logic [2*ADC_W-1:0]    r_p;
    logic                  r_rail;
    logic                  r_kz;
    logic                  w_accept;
    logic [ADC_W-1:0]      w_diff;
    logic [NUM_W-1:0]      w_num;

    assign o_full      = r_fv && i_q_full;
    assign o_item_push = r_fv && !i_q_full;
    assign w_accept    = i_push && !o_full;
    assign w_diff      = ADC_MAX - i_adc_sample;
    assign w_num       = {{(NUM_W-2*ADC_W){1'b0}}, r_p} * NUM_W'(1000);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (w_accept) begin
            r_fv <= 1'b1;
        end else if (o_item_push) begin
            r_fv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x    <= i_adc_sample;
            r_p    <= {{ADC_W{1'b0}}, i_series_kohm} * {{ADC_W{1'b0}}, w_diff};
            r_rail <= (i_adc_sample == '0) || (i_adc_sample == ADC_MAX);
            r_kz   <= (i_series_kohm == '0);
        end
    end

    always_comb begin
        o_item.adc_sample = r_x;
        o_item.num        = w_num;
        o_item.rail       = r_rail;
        o_item.kzero      = r_kz;
    end

endmodule

// ===== rtl/thta_fifo.sv =====
// Two-entry queue between front end and conversion engine.
// Depends on thta_pkg for the item type.
module thta_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  thta_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output thta_pkg::t_item o_item,
    output logic            o_empty
);
    import thta_pkg::*;

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

// ===== rtl/thta_div.sv =====
// Shared restoring divider: 16 quotient bits, one per cycle, with an
// up-front overflow test. Depends on thta_pkg for request and response types.
module thta_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  thta_pkg::t_div_req i_req,
    output thta_pkg::t_div_rsp o_rsp
);
    import thta_pkg::*;

    localparam int WW  = DIV_W + QUO_W;
    localparam int CNT_W = $clog2(QUO_W);

    logic             r_busy;
    logic             r_done;
    logic             r_ovf;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_rem;
    logic [WW-1:0]    r_dsr;
    logic [QUO_W-1:0] r_quo;
    logic             w_big;
    logic             w_ge;
    logic [WW-1:0]    w_diff;

    assign w_big  = {{QUO_W{1'b0}}, i_req.num} >= {i_req.den, {QUO_W{1'b0}}};
    assign w_ge   = {{QUO_W{1'b0}}, r_rem} >= r_dsr;
    assign w_diff = {{QUO_W{1'b0}}, r_rem} - r_dsr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= !w_big;
                r_done <= w_big;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_ovf <= w_big;
            r_rem <= i_req.num;
            r_dsr <= {1'b0, i_req.den, {(QUO_W-1){1'b0}}};
            r_cnt <= CNT_W'(QUO_W-1);
            r_quo <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= w_diff[DIV_W-1:0];
            end
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
            r_dsr <= r_dsr >> 1;
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_comb begin
        o_rsp.done = r_done;
        o_rsp.ovf  = r_ovf;
        o_rsp.quo  = r_quo;
    end

endmodule

// ===== rtl/thta_back.sv =====
// Conversion engine: log2 by repeated squaring, Steinhart-Hart polynomial,
// Fahrenheit scaling and the moving average. Depends on thta_pkg, thta_ram.
module thta_back #(
    parameter int AVG_DEPTH = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_empty,
    input  thta_pkg::t_item                     i_q_item,
    output logic                                o_q_pop,
    input  logic signed [thta_pkg::COEF_W-1:0]  i_coef_a,
    input  logic signed [thta_pkg::COEF_W-1:0]  i_coef_b,
    input  logic signed [thta_pkg::COEF_W-1:0]  i_coef_c,
    output thta_pkg::t_div_req                  o_div_req,
    input  thta_pkg::t_div_rsp                  i_div_rsp,
    output logic                                o_empty,
    input  logic                                i_pop,
    output logic signed [thta_pkg::TEMP_W-1:0]  o_instant_temp,
    output logic signed [thta_pkg::TEMP_W-1:0]  o_average_temp,
    output logic                                o_rail_fault
);
    import thta_pkg::*;

    localparam int SLOT_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int TOT_W  = TEMP_W + 1 + $clog2(AVG_DEPTH);
    localparam logic [31:0]        LN2_Q32   = 32'd2977044472;
    localparam logic signed [63:0] TOP_BIAS  = 64'sd180 <<< 40;
    localparam logic signed [63:0] TOP_GAIN  = 64'sd45967;
    localparam logic [4:0]         LAST_STEP = 5'd23;
    localparam logic [4:0]         TOP_EXP   = 5'd31;

    t_state r_state, n_state;

    t_item                     r_item;
    logic                      r_pass;
    logic [31:0]               r_m;
    logic [4:0]                r_e;
    logic [23:0]               r_frac;
    logic [4:0]                r_cnt;
    logic [28:0]               r_lg_num;
    logic signed [21:0]        r_lnr;
    logic signed [25:0]        r_l2;
    logic signed [31:0]        r_l3;
    logic signed [37:0]        r_tb;
    logic signed [47:0]        r_tc;
    logic signed [47:0]        r_s;
    logic signed [63:0]        r_top;
    logic signed [51:0]        r_den;
    logic                      r_neg;
    logic signed [TEMP_W-1:0]  r_inst;
    logic signed [TEMP_W-1:0]  r_avg;
    logic signed [TEMP_W-1:0]  r_first;
    logic signed [TOT_W-1:0]   r_tot;
    logic [SLOT_W-1:0]         r_slot;
    logic                      r_primed;
    logic                      r_filled;
    logic                      r_ov;
    logic signed [TEMP_W-1:0]  r_out_inst;
    logic signed [TEMP_W-1:0]  r_out_avg;
    logic                      r_out_fault;

    logic                      w_ram_we;
    logic                      w_load;
    logic [TEMP_W-1:0]         w_ring_rd;
    logic [63:0]               w_sq;
    logic [32:0]               w_sqs;
    logic [31:0]               w_m_nx;
    logic [23:0]               w_frac_nx;
    logic signed [29:0]        w_d;
    logic [29:0]               w_dneg;
    logic [28:0]               w_ad;
    logic [60:0]               w_lp;
    logic [21:0]               w_lmag;
    logic signed [43:0]        w_p2;
    logic signed [47:0]        w_p3;
    logic signed [47:0]        w_p3b;
    logic signed [53:0]        w_pb;
    logic signed [53:0]        w_pbb;
    logic signed [63:0]        w_pc;
    logic signed [63:0]        w_pcb;
    logic signed [63:0]        w_top;
    logic signed [51:0]        w_den;
    logic [63:0]               w_top_neg;
    logic [51:0]               w_den_neg;
    logic signed [TEMP_W-1:0]  w_old;
    logic signed [TOT_W-1:0]   w_tot_new;
    logic [TOT_W-1:0]          w_tot_neg;
    logic [SLOT_W:0]           w_slot_inc;
    logic [SLOT_W-1:0]         w_next_slot;
    logic signed [TEMP_W-1:0]  w_sat;

    function automatic logic signed [TEMP_W-1:0] sat_q(
        input logic neg,
        input logic ovf,
        input logic [QUO_W-1:0] mag
    );
        logic signed [TEMP_W-1:0] res;
        if (neg) begin
            if (ovf || (mag > 16'd32768)) begin
                res = 16'sh8000;
            end else begin
                res = $signed(16'(~mag + 16'd1));
            end
        end else begin
            if (ovf || (mag > 16'd32767)) begin
                res = TEMP_MAX;
            end else begin
                res = $signed(mag);
            end
        end
        return res;
    endfunction

    thta_ram #(
        .WIDTH (TEMP_W),
        .DEPTH (AVG_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_slot),
        .i_wdata (r_inst),
        .i_raddr (r_slot),
        .o_rdata (w_ring_rd)
    );

    assign w_sq      = {32'b0, r_m} * {32'b0, r_m};
    assign w_sqs     = w_sq[63:31];
    assign w_m_nx    = w_sqs[32] ? w_sqs[32:1] : w_sqs[31:0];
    assign w_frac_nx = {r_frac[22:0], w_sqs[32]};

    assign w_d    = $signed({1'b0, r_lg_num}) - $signed({1'b0, r_e, r_frac});
    assign w_dneg = -w_d;
    assign w_ad   = w_d[29] ? w_dneg[28:0] : w_d[28:0];
    assign w_lp   = {32'b0, w_ad} * {29'b0, LN2_Q32};
    assign w_lmag = {1'b0, w_lp[60:40]};

    assign w_p2  = 44'(r_lnr) * 44'(r_lnr);
    assign w_p3  = 48'(r_l2) * 48'(r_lnr);
    assign w_p3b = w_p3 + (w_p3[47] ? 48'sd65535 : 48'sd0);
    assign w_pb  = 54'(i_coef_b) * 54'(r_lnr);
    assign w_pbb = w_pb + (w_pb[53] ? 54'sd65535 : 54'sd0);
    assign w_pc  = 64'(i_coef_c) * 64'(r_l3);
    assign w_pcb = w_pc + (w_pc[63] ? 64'sd65535 : 64'sd0);

    assign w_top     = TOP_BIAS - 64'(r_s) * TOP_GAIN;
    assign w_den     = (52'(r_s) <<< 3) + (52'(r_s) <<< 1);
    assign w_top_neg = -r_top;
    assign w_den_neg = -r_den;

    assign w_old       = r_filled ? $signed(w_ring_rd) : r_first;
    assign w_tot_new   = r_primed ? (r_tot - TOT_W'(w_old) + TOT_W'(r_inst))
                                  : (TOT_W'(r_inst) * TOT_W'(AVG_DEPTH));
    assign w_tot_neg   = -r_tot;
    assign w_slot_inc  = {1'b0, r_slot} + (SLOT_W+1)'(1);
    assign w_next_slot = (w_slot_inc == (SLOT_W+1)'(AVG_DEPTH)) ? '0
                                                                : w_slot_inc[SLOT_W-1:0];
    assign w_sat       = sat_q(r_neg, i_div_rsp.ovf, i_div_rsp.quo);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    n_state = (i_q_item.rail || i_q_item.kzero) ? ST_AVG : ST_NORM;
                end
            end
            ST_NORM: begin
                if (r_m[31]) begin
                    n_state = ST_SQR;
                end
            end
            ST_SQR: begin
                if (r_cnt == LAST_STEP) begin
                    n_state = r_pass ? ST_LN : ST_NORM;
                end
            end
            ST_LN:     n_state = ST_L2;
            ST_L2:     n_state = ST_L3;
            ST_L3:     n_state = ST_TB;
            ST_TB:     n_state = ST_TC;
            ST_TC:     n_state = ST_SUM;
            ST_SUM:    n_state = ST_TOP;
            ST_TOP:    n_state = (r_s == '0) ? ST_AVG : ST_TSTART;
            ST_TSTART: n_state = ST_TDIV;
            ST_TDIV: begin
                if (i_div_rsp.done) begin
                    n_state = ST_AVG;
                end
            end
            ST_AVG:    n_state = r_primed ? ST_ASTART : ST_OUT;
            ST_ASTART: n_state = ST_ADIV;
            ST_ADIV: begin
                if (i_div_rsp.done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_ov || i_pop) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop         = 1'b0;
        w_ram_we        = 1'b0;
        w_load          = 1'b0;
        o_div_req.start = 1'b0;
        o_div_req.num   = w_top[63] ? '0 : '0;
        o_div_req.den   = '0;
        case (r_state)
            ST_IDLE: begin
                o_q_pop = !i_q_empty;
            end
            ST_TSTART: begin
                o_div_req.start = 1'b1;
                o_div_req.num   = r_top[63] ? w_top_neg : r_top;
                o_div_req.den   = {12'b0, (r_den[51] ? w_den_neg : r_den)};
            end
            ST_AVG: begin
                w_ram_we = 1'b1;
            end
            ST_ASTART: begin
                o_div_req.start = 1'b1;
                o_div_req.num   = {{(DIV_W-TOT_W){1'b0}},
                                   (r_tot[TOT_W-1] ? w_tot_neg : r_tot)};
                o_div_req.den   = DIV_W'(AVG_DEPTH);
            end
            ST_OUT: begin
                w_load = !r_ov || i_pop;
            end
            default: begin
                o_q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_tot    <= '0;
            r_slot   <= '0;
            r_primed <= 1'b0;
            r_filled <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_AVG) begin
                r_tot    <= w_tot_new;
                r_slot   <= w_next_slot;
                r_primed <= 1'b1;
                r_filled <= r_filled || (w_next_slot == '0);
            end
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_item <= i_q_item;
                r_m    <= {2'b0, i_q_item.num};
                r_e    <= TOP_EXP;
                r_pass <= 1'b0;
                r_inst <= RAIL_TENTHS;
            end
            ST_NORM: begin
                if (r_m[31]) begin
                    r_cnt  <= '0;
                    r_frac <= '0;
                end else if (r_m[31:28] == 4'd0) begin
                    r_m <= r_m << 4;
                    r_e <= r_e - 5'd4;
                end else begin
                    r_m <= r_m << 1;
                    r_e <= r_e - 5'd1;
                end
            end
            ST_SQR: begin
                r_m    <= w_m_nx;
                r_frac <= w_frac_nx;
                r_cnt  <= r_cnt + 5'd1;
                if ((r_cnt == LAST_STEP) && !r_pass) begin
                    r_lg_num <= {r_e, w_frac_nx};
                    r_pass   <= 1'b1;
                    r_m      <= {22'b0, r_item.adc_sample};
                    r_e      <= TOP_EXP;
                end
            end
            ST_LN: begin
                r_lnr <= w_d[29] ? $signed(-w_lmag) : $signed(w_lmag);
            end
            ST_L2: begin
                r_l2 <= w_p2[41:16];
            end
            ST_L3: begin
                r_l3 <= w_p3b[47:16];
            end
            ST_TB: begin
                r_tb <= w_pbb[53:16];
            end
            ST_TC: begin
                r_tc <= w_pcb[63:16];
            end
            ST_SUM: begin
                r_s <= 48'(i_coef_a) + 48'(r_tb) + r_tc;
            end
            ST_TOP: begin
                r_top  <= w_top;
                r_den  <= w_den;
                r_neg  <= w_top[63] ^ r_s[47];
                r_inst <= TEMP_MAX;
            end
            ST_TDIV: begin
                if (i_div_rsp.done) begin
                    r_inst <= w_sat;
                end
            end
            ST_AVG: begin
                r_neg <= w_tot_new[TOT_W-1];
                r_avg <= r_inst;
                if (!r_primed) begin
                    r_first <= r_inst;
                end
            end
            ST_ADIV: begin
                if (i_div_rsp.done) begin
                    r_avg <= w_sat;
                end
            end
            default: begin
                r_neg <= r_neg;
            end
        endcase
        if (w_load) begin
            r_out_inst  <= r_inst;
            r_out_avg   <= r_avg;
            r_out_fault <= r_item.rail;
        end
    end

    assign o_empty        = !r_ov;
    assign o_instant_temp = r_out_inst;
    assign o_average_temp = r_out_avg;
    assign o_rail_fault   = r_out_fault;

endmodule

// ===== rtl/thermistor_temperature_averager_top.sv =====
// Converts 10-bit thermistor divider samples to tenths of a degree Fahrenheit
// (Steinhart-Hart) and keeps a moving average over AVG_DEPTH results. A sample
// is taken when push is high and full is low; the result (instant, average,
// rail fault) waits on the outputs while empty is low and leaves on pop. Each
// sample goes through the conversion engine as two log2 passes, each a
// normalize phase plus 24 squarings on one 32x32 multiplier, then seven
// polynomial steps and two passes through the shared divider. A rail sample
// or a zero series resistor skips the log, polynomial and temperature divide;
// the first sample after reset and a zero polynomial sum each skip one
// divider pass. The front end and a two-entry queue take up to three further
// samples while the engine works. The user must write coefficients and the
// series resistor through the cfg port only while the block is idle; the
// block itself does not enforce this.
// Depends on thta_pkg, thta_front, thta_fifo, thta_div, thta_back, thta_ram.
module thermistor_temperature_averager_top #(
    parameter int AVG_DEPTH = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [thta_pkg::ADC_W-1:0]          i_adc_sample,
    input  logic                                pop,
    output logic                                empty,
    output logic signed [thta_pkg::TEMP_W-1:0]  o_instant_temp,
    output logic signed [thta_pkg::TEMP_W-1:0]  o_average_temp,
    output logic                                o_rail_fault,
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_idx,
    input  logic [thta_pkg::COEF_W-1:0]         i_cfg_data
);
    import thta_pkg::*;

    logic signed [COEF_W-1:0] r_coef_a;
    logic signed [COEF_W-1:0] r_coef_b;
    logic signed [COEF_W-1:0] r_coef_c;
    logic [KOHM_W-1:0]        r_series;

    t_item    w_f_item;
    logic     w_f_push;
    logic     w_q_full;
    t_item    w_q_item;
    logic     w_q_empty;
    logic     w_q_pop;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a <= COEF_A_RST;
            r_coef_b <= COEF_B_RST;
            r_coef_c <= COEF_C_RST;
            r_series <= SERIES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_COEF_A: r_coef_a <= $signed(i_cfg_data);
                REG_COEF_B: r_coef_b <= $signed(i_cfg_data);
                REG_COEF_C: r_coef_c <= $signed(i_cfg_data);
                REG_SERIES: r_series <= i_cfg_data[KOHM_W-1:0];
                default:    r_series <= r_series;
            endcase
        end
    end

    thta_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_adc_sample  (i_adc_sample),
        .i_series_kohm (r_series),
        .o_item_push   (w_f_push),
        .o_item        (w_f_item),
        .i_q_full      (w_q_full)
    );

    thta_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_push),
        .i_item  (w_f_item),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_item  (w_q_item),
        .o_empty (w_q_empty)
    );

    thta_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    thta_back #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (w_q_empty),
        .i_q_item       (w_q_item),
        .o_q_pop        (w_q_pop),
        .i_coef_a       (r_coef_a),
        .i_coef_b       (r_coef_b),
        .i_coef_c       (r_coef_c),
        .o_div_req      (w_div_req),
        .i_div_rsp      (w_div_rsp),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_instant_temp (o_instant_temp),
        .o_average_temp (o_average_temp),
        .o_rail_fault   (o_rail_fault)
    );

endmodule

// ===== rtl/thta_checker.sv =====
// Port-level checks for the thermistor temperature averager, bound to the top.
// Depends on thermistor_temperature_averager_top.
module thta_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               push,
    input logic               full,
    input logic               pop,
    input logic               empty,
    input logic signed [15:0] o_instant_temp,
    input logic signed [15:0] o_average_temp,
    input logic               o_rail_fault
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("result or full flag set after reset");

    a_beat_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_instant_temp)
                           && $stable(o_average_temp) && $stable(o_rail_fault))
        else $error("waiting result beat changed");

    a_rail_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_rail_fault |-> o_instant_temp == -16'sd4596)
        else $error("rail fault without rail temperature");

    a_full_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push))
        else $error("full raised without an input beat");

endmodule

bind thermistor_temperature_averager_top thta_checker u_chk (.*);
